// File: rtl/sdpd_pkg.sv
package sdpd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned LenW   = 8;
  localparam int unsigned IdxW   = 17;
  localparam int unsigned FrameW = 18;
  localparam int unsigned BitIdxW = 3;

  // Queue between the byte front end and the run back end.
  localparam int unsigned QDepth = 4;

  localparam int unsigned MaxFramePixelsDef = 131072;

  localparam logic              CfgResetMode  = 1'b1;
  localparam logic [FrameW-1:0] CfgResetFrame = 18'd76800;

  localparam logic [RgbW-1:0] PixBlack = 24'h000000;
  localparam logic [RgbW-1:0] PixWhite = 24'hFFFFFF;

  typedef enum logic {
    ModeMono   = 1'b0,
    ModeColour = 1'b1
  } mode_e;

  typedef enum logic {
    CfgDecodeMode  = 1'b0,
    CfgFramePixels = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KindData    = 1'b0,
    KindRestart = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OpRestart = 2'd0,
    OpMono    = 2'd1,
    OpColour  = 2'd2
  } cmd_op_e;

  // One decoded command. For mono, arg is the assembled bitmap byte;
  // for color, arg is the run count (never zero).
  typedef struct packed {
    cmd_op_e         op;
    logic [RgbW-1:0] rgb;
    logic [ByteW-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [LenW-1:0] len;
    logic [RgbW-1:0] rgb;
    logic            done;
    logic            last;
  } run_t;

endpackage

// File: rtl/sdpd_front.sv
module sdpd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 kind_i,
  input  logic [7:0]           byte_i,
  input  logic                 mode_i,
  input  logic                 full_i,
  output logic                 push_o,
  output sdpd_pkg::cmd_t       cmd_o
);
  import sdpd_pkg::*;

  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseOne  = 2'd1;
  localparam logic [1:0] PhaseTwo  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] held1_q, held1_d;
  logic [ByteW-1:0] held2_q, held2_d;
  logic             accept;
  logic [ByteW-1:0] nib_hi, nib_lo;
  logic [15:0]      word;
  logic [4:0]       red5, blue5;
  logic [5:0]       green6;

  // Lowercase hex to value, wrapping for characters that are not hex.
  function automatic logic [ByteW-1:0] hex_nibble(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else            v = c - 8'h57;
    return v;
  endfunction

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  assign nib_hi = hex_nibble(held1_q);
  assign nib_lo = hex_nibble(byte_i);
  assign word   = {held1_q, held2_q};
  assign red5   = word[4:0];
  assign green6 = word[10:5];
  assign blue5  = word[15:11];

  always_comb begin
    phase_d   = phase_q;
    held1_d   = held1_q;
    held2_d   = held2_q;
    push_o    = 1'b0;
    cmd_o.op  = OpRestart;
    cmd_o.rgb = {red5, {3{red5[4]}}, green6, {2{green6[5]}}, blue5, {3{blue5[4]}}};
    cmd_o.arg = byte_i;
    if (accept) begin
      if (kind_e'(kind_i) == KindRestart) begin
        phase_d = PhaseIdle;
        held1_d = '0;
        held2_d = '0;
        push_o  = 1'b1;
      end else if (mode_e'(mode_i) == ModeMono) begin
        if (phase_q == PhaseIdle) begin
          held1_d = byte_i;
          phase_d = PhaseOne;
        end else begin
          phase_d   = PhaseIdle;
          push_o    = 1'b1;
          cmd_o.op  = OpMono;
          cmd_o.arg = nib_lo | {nib_hi[3:0], 4'b0000};
        end
      end else begin
        if (phase_q == PhaseIdle) begin
          held1_d = byte_i;
          phase_d = PhaseOne;
        end else if (phase_q == PhaseOne) begin
          held2_d = byte_i;
          phase_d = PhaseTwo;
        end else begin
          phase_d  = PhaseIdle;
          push_o   = (byte_i != '0);
          cmd_o.op = OpColour;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      held1_q <= '0;
      held2_q <= '0;
    end else begin
      phase_q <= phase_d;
      held1_q <= held1_d;
      held2_q <= held2_d;
    end
  end

endmodule

// File: rtl/sdpd_fifo.sv
module sdpd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdpd_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output sdpd_pkg::cmd_t head_o
);
  import sdpd_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/sdpd_back.sv
module sdpd_back #(
  parameter int unsigned MaxFramePixels = sdpd_pkg::MaxFramePixelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sdpd_pkg::FrameW-1:0]   frame_pixels_i,
  input  logic                          empty_i,
  input  sdpd_pkg::cmd_t                head_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output sdpd_pkg::run_t                run_o
);
  import sdpd_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxFramePixels);
  localparam int unsigned LimW  = $clog2(MaxFramePixels + 1);
  localparam int unsigned CalcW = (LimW > ByteW) ? LimW : ByteW;
  localparam int unsigned FpW   = (LimW > FrameW) ? LimW : FrameW;
  localparam logic [FpW-1:0] MaxFp = FpW'(MaxFramePixels);

  logic [CntW-1:0]    count_q, count_d;
  logic               busy_q, busy_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic               ovalid_q, ovalid_d;
  run_t               out_q, out_d;

  logic [FpW-1:0]     fp_x;
  logic [LimW-1:0]    lim;
  logic [CalcW-1:0]   count_x, lim_x, room, arg_x;
  logic               can_emit;
  logic [ByteW-1:0]   mono_byte;
  logic [BitIdxW-1:0] mono_bit;
  logic               mono_pix, mono_done, mono_last;
  logic               col_fit, col_done;
  logic [LenW-1:0]    col_len;

  // A frame size of zero acts as one, and sizes above the limit are clamped.
  assign fp_x = FpW'(frame_pixels_i);
  always_comb begin
    if (fp_x == '0)        lim = LimW'(1);
    else if (fp_x > MaxFp) lim = LimW'(MaxFp);
    else                   lim = LimW'(fp_x);
  end

  assign count_x  = CalcW'(count_q);
  assign lim_x    = CalcW'(lim);
  assign can_emit = !ovalid_q || ready_i;

  assign mono_byte = busy_q ? byte_q : head_i.arg;
  assign mono_bit  = busy_q ? bit_q : '0;
  assign mono_pix  = mono_byte[BitIdxW'(7) - mono_bit];
  assign mono_done = (count_x + CalcW'(1)) >= lim_x;
  assign mono_last = mono_done || (mono_bit == BitIdxW'(7));

  // The run is trimmed to what is left in the frame. Once the count has
  // reached or passed the frame size, the run shrinks to a single pixel.
  assign room     = (count_x < lim_x) ? (lim_x - count_x) : CalcW'(1);
  assign arg_x    = CalcW'(head_i.arg);
  assign col_fit  = arg_x < room;
  assign col_len  = col_fit ? head_i.arg : LenW'(room);
  assign col_done = (count_x >= lim_x) || !col_fit;

  always_comb begin
    count_d  = count_q;
    busy_d   = busy_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    ovalid_d = ovalid_q && !ready_i;
    out_d    = out_q;
    pop_o    = 1'b0;
    if (busy_q || (!empty_i && head_i.op == OpMono)) begin
      if (can_emit) begin
        pop_o      = !busy_q;
        ovalid_d   = 1'b1;
        out_d.rgb  = mono_pix ? PixBlack : PixWhite;
        out_d.len  = LenW'(1);
        out_d.idx  = IdxW'(count_q);
        out_d.done = mono_done;
        out_d.last = mono_last;
        count_d    = mono_done ? '0 : count_q + CntW'(1);
        busy_d     = !mono_last;
        byte_d     = mono_byte;
        bit_d      = mono_bit + BitIdxW'(1);
      end
    end else if (!empty_i) begin
      if (head_i.op == OpRestart) begin
        pop_o   = 1'b1;
        count_d = '0;
      end else if (can_emit) begin
        pop_o      = 1'b1;
        ovalid_d   = 1'b1;
        out_d.rgb  = head_i.rgb;
        out_d.len  = col_len;
        out_d.idx  = IdxW'(count_q);
        out_d.done = col_done;
        out_d.last = 1'b1;
        count_d    = col_done ? '0 : count_q + CntW'(col_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign valid_o = ovalid_q;
  assign run_o   = out_q;

endmodule

// File: rtl/screen_dump_pixel_decoder.sv
// Screen-dump pixel decoder. Received bytes arrive as beats on the slave
// stream (tuser set marks a restart beat that clears the byte phase and the
// pixel count) and leave as pixel runs on the master stream, each with its
// 24-bit color, length, frame position and end-of-frame flag. In mono mode
// two hex characters form a bitmap byte that yields up to eight one-pixel
// runs; in color mode a high/low/count byte triple yields one run unless
// its count is zero. The input side registers the byte phase and pushes
// decoded commands into a four-entry queue; the run generator drains that
// queue and emits one run per cycle through an output register when the
// sink is ready, so a run generator stalled by the sink does not stop input
// beats until the queue fills.
// Configuration writes (index 0 decode_mode, index 1 frame_pixels) are
// always accepted and should be made while the block is idle.
module screen_dump_pixel_decoder #(
  parameter int unsigned MaxFramePixels = sdpd_pkg::MaxFramePixelsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Slave stream.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                        s_axis_tuser_i,  // [0] kind
  // Master stream.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [23:0] pixel_rgb, [31:24] run_length, [48:32] pixel_index, [55:49] zero
  output logic [55:0]                 m_axis_tdata_o,
  output logic                        m_axis_tlast_o,  // frame_done
  output logic                        m_axis_tuser_o,  // [0] last_of_item
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [sdpd_pkg::FrameW-1:0] cfg_data_i
);
  import sdpd_pkg::*;

  logic              mode_q;
  logic [FrameW-1:0] frame_q;
  logic              push, pop, full, empty;
  cmd_t              push_cmd, head;
  run_t              run;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= CfgResetMode;
      frame_q <= CfgResetFrame;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgDecodeMode:  mode_q  <= cfg_data_i[0];
        CfgFramePixels: frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end tracks the byte phase and decodes complete groups.
  sdpd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .kind_i  (s_axis_tuser_i),
    .byte_i  (s_axis_tdata_i),
    .mode_i  (mode_q),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  sdpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // The back end owns the pixel count and produces the runs.
  sdpd_back #(
    .MaxFramePixels (MaxFramePixels)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_pixels_i (frame_q),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid_o),
    .ready_i        (m_axis_tready_i),
    .run_o          (run)
  );

  assign m_axis_tdata_o = {7'b0000000, run.idx, run.len, run.rgb};
  assign m_axis_tlast_o = run.done;
  assign m_axis_tuser_o = run.last;

endmodule

// File: dv/tb_screen_dump_pixel_decoder.sv
`timescale 1ns / 1ps

// Testbench for the screen-dump pixel decoder. A short directed table opens the
// run; a few of its rows carry a hand-written expected run, the rest are
// checked against the local decoder model. Random phases follow, each with a
// fresh register setting written while the block is idle. The byte sender
// works in bursts with random gaps, and the run sink stalls on patterns of its
// own.
module tb_screen_dump_pixel_decoder;
  import sdpd_pkg::*;

  localparam int unsigned RandomItems  = 480;
  // A margin for a run pipeline still draining.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TimeoutNs    = 4_000_000;
  localparam int unsigned MaxPrinted   = 100;

  // Bit positions of the result fields inside m_axis_tdata_o.
  localparam int unsigned LenLo = RgbW;
  localparam int unsigned IdxLo = RgbW + LenW;

  // Directed rows either send one beat or write one register.
  typedef enum logic {
    RowBeat,
    RowCfg
  } step_e;

  typedef struct packed {
    step_e             op;
    kind_e             kind;
    logic [ByteW-1:0]  data;
    cfg_reg_e          sel;
    logic [FrameW-1:0] value;
    logic              typed;  // want holds the only run this beat causes
    run_t              want;   // fields: idx, len, rgb, done, last
  } step_row_t;

  // How the run sink spends a stretch of cycles.
  typedef enum logic [1:0] {
    SinkOpen,
    SinkLoose,
    SinkTight,
    SinkPeriodic
  } sink_style_e;

  localparam int unsigned NumSteps = 36;

  // The directed table starts from the reset setting: color mode, a frame of
  // 76800 pixels.
  localparam step_row_t DirSteps [NumSteps] = '{
    // Pure red at the extreme of the red channel, five pixels from index 0.
    '{RowBeat, KindData, 8'h00, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h1F, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h05, CfgDecodeMode, 18'd0, 1'b1,
      '{17'd0, 8'd5, 24'hFF0000, 1'b0, 1'b1}},
    // All channels at full scale with the longest run.
    '{RowBeat, KindData, 8'hFF, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'hFF, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'hFF, CfgDecodeMode, 18'd0, 1'b1,
      '{17'd5, 8'd255, 24'hFFFFFF, 1'b0, 1'b1}},
    // A zero count emits nothing and only realigns the byte phase.
    '{RowBeat, KindData, 8'h12, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h34, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h00, CfgDecodeMode, 18'd0, 1'b0, '0},
    // Shrink the frame below the pixel count: the next run is cut to one
    // pixel and ends the frame.
    '{RowCfg,  KindData, 8'h00, CfgFramePixels, 18'd1, 1'b0, '0},
    '{RowBeat, KindData, 8'hAB, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'hCD, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h40, CfgDecodeMode, 18'd0, 1'b0, '0},
    // Mono mode with a 20-pixel frame: "ff", "00", then two non-hex bytes
    // whose byte ends the frame partway through its bits.
    '{RowCfg,  KindData, 8'h00, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowCfg,  KindData, 8'h00, CfgFramePixels, 18'd20, 1'b0, '0},
    '{RowBeat, KindData, 8'h66, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h66, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h30, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h30, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h00, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'hFF, CfgDecodeMode, 18'd0, 1'b0, '0},
    // An uppercase first character is dropped by a restart.
    '{RowBeat, KindData, 8'h41, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindRestart, 8'hC3, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h61, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h35, CfgDecodeMode, 18'd0, 1'b0, '0},
    // Switch to color with one character held, and a frame size of zero.
    '{RowBeat, KindData, 8'h37, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowCfg,  KindData, 8'h00, CfgDecodeMode, 18'd1, 1'b0, '0},
    '{RowCfg,  KindData, 8'h00, CfgFramePixels, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h12, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h03, CfgDecodeMode, 18'd0, 1'b0, '0},
    // Frame size beyond the maximum; switch to mono with two bytes held.
    '{RowCfg,  KindData, 8'h00, CfgFramePixels, 18'h3FFFF, 1'b0, '0},
    '{RowBeat, KindData, 8'h11, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h22, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowCfg,  KindData, 8'h00, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowBeat, KindData, 8'h33, CfgDecodeMode, 18'd0, 1'b0, '0},
    '{RowCfg,  KindData, 8'h00, CfgFramePixels, 18'd131072, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;   // [7:0] data_byte
  logic                s_axis_tuser_i;   // [0] kind
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [23:0] pixel_rgb, [31:24] run_length, [48:32] pixel_index, [55:49] zero
  logic [55:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;   // [0] frame_done
  logic                m_axis_tuser_o;   // [0] last_of_item
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [FrameW-1:0]   cfg_data_i;

  screen_dump_pixel_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Decoder model state: its own copy of the registers and of the byte
  // assembly and pixel counting.
  mode_e             model_mode;
  logic [FrameW-1:0] model_frame;
  logic [1:0]        model_phase;
  logic [ByteW-1:0]  model_hi;
  logic [ByteW-1:0]  model_lo;
  logic [IdxW-1:0]   model_count;

  // Runs predicted but not yet seen on the master stream, oldest first.
  run_t        pending_runs [$];
  run_t        oldest;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want);
    end
  endtask

  // A character becomes c - '0' up to '9' and c - 'a' + 10 above it, with
  // 8-bit wrap, so any byte yields some value.
  function automatic logic [7:0] ascii_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else v = c + 8'd10 - 8'h61;
    return v;
  endfunction

  // Channel widening: the freed low bits copy the channel's top bit.
  function automatic logic [7:0] stretch5(input logic [4:0] v);
    return {v, {3{v[4]}}};
  endfunction

  function automatic logic [7:0] stretch6(input logic [5:0] v);
    return {v, {2{v[5]}}};
  endfunction

  function automatic logic [7:0] lower_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'(8'h30 + v) : 8'(8'h61 + v - 10);
  endfunction

  // Mostly small frames so that frame ends come often, with the edges and
  // out-of-range sizes mixed in.
  function automatic logic [FrameW-1:0] pick_frame();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FrameW'(MaxFramePixelsDef);
      2: return FrameW'($urandom_range(MaxFramePixelsDef + 1, 262143));
      3: return CfgResetFrame;
      4: return FrameW'($urandom_range(1, 2000));
      default: return FrameW'($urandom_range(1, 64));
    endcase
  endfunction

  // Steps the model by one accepted beat and queues the runs it causes.
  task automatic decode_beat(input kind_e k, input logic [7:0] b);
    int unsigned lim;
    int unsigned cnt;
    int unsigned room;
    int unsigned len;
    logic [7:0]  bits;
    logic [7:0]  first_nib;
    logic [15:0] word;
    run_t        r;
    lim = model_frame;
    if (lim == 0) lim = 1;
    if (lim > MaxFramePixelsDef) lim = MaxFramePixelsDef;
    cnt = model_count;
    if (k == KindRestart) begin
      model_phase = '0;
      model_hi    = '0;
      model_lo    = '0;
      model_count = '0;
      return;
    end
    if (model_phase == 2'd0) begin
      model_hi    = b;
      model_phase = 2'd1;
      return;
    end
    if (model_mode == ModeMono) begin
      // Any nonzero phase takes this byte as the second character.
      model_phase = 2'd0;
      first_nib   = ascii_nibble(model_hi);
      bits        = {first_nib[3:0], 4'b0000} | ascii_nibble(b);
      for (int i = 7; i >= 0; i--) begin
        r.rgb  = bits[i] ? PixBlack : PixWhite;
        r.len  = 8'd1;
        r.idx  = IdxW'(cnt);
        r.done = (cnt + 1 >= lim);
        r.last = r.done || (i == 0);
        pending_runs.push_back(r);
        // Bits after the one that ends the frame are dropped.
        if (r.done) begin
          cnt = 0;
          break;
        end
        cnt++;
      end
    end else if (model_phase == 2'd1) begin
      model_lo    = b;
      model_phase = 2'd2;
      return;
    end else begin
      model_phase = 2'd0;
      if (b == 8'd0) return;
      word   = {model_hi, model_lo};
      r.rgb  = {stretch5(word[4:0]), stretch6(word[10:5]), stretch5(word[15:11])};
      // At or past the frame end the run shrinks to a single pixel.
      room   = (cnt < lim) ? lim - cnt : 1;
      len    = (b < room) ? b : room;
      r.len  = 8'(len);
      r.idx  = IdxW'(cnt);
      r.done = (cnt + len >= lim);
      r.last = 1'b1;
      pending_runs.push_back(r);
      cnt = r.done ? 0 : cnt + len;
    end
    model_count = IdxW'(cnt);
  endtask

  // Sends one beat. Valid stays high on return so that a following beat can
  // reuse it; whoever stops sending lowers it.
  task automatic push_beat(input kind_e k, input logic [7:0] d,
                           input logic typed = 1'b0, input run_t want = '0);
    int unsigned gap;
    int unsigned held;
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= k;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    held = pending_runs.size();
    decode_beat(k, d);
    if (typed) begin
      while (pending_runs.size() > held) void'(pending_runs.pop_back());
      pending_runs.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // Writes one register; valid is lowered by the next beat or idle wait.
  task automatic write_reg(input cfg_reg_e sel, input logic [FrameW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == CfgDecodeMode) model_mode = mode_e'(value[0]);
    else model_frame = value;
    @(negedge clk_i);
  endtask

  // Stops both input channels, waits for every predicted run, then lets the
  // block settle in case the last beats left work without a run.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Run sink: each stretch picks a stall style, including stretches that
  // never stall.
  initial begin : sink_stalls
    sink_style_e style;
    int unsigned span;
    int unsigned tick;
    m_axis_tready_i <= 1'b0;
    tick = 0;
    forever begin
      style = sink_style_e'($urandom_range(0, 3));
      span  = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (style)
          SinkOpen:  m_axis_tready_i <= 1'b1;
          SinkLoose: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          SinkTight: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready_i <= ((tick % 9) < 5);
        endcase
      end
    end
  end

  // Every accepted run is compared field by field with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("unpredicted run", m_axis_tdata_o[31:0], '0);
      end else begin
        oldest = pending_runs.pop_front();
        if (m_axis_tdata_o[RgbW-1:0] != oldest.rgb) begin
          report_mismatch("pixel_rgb", m_axis_tdata_o[RgbW-1:0], oldest.rgb);
        end
        if (m_axis_tdata_o[LenLo+LenW-1:LenLo] != oldest.len) begin
          report_mismatch("run_length", m_axis_tdata_o[LenLo+LenW-1:LenLo], oldest.len);
        end
        if (m_axis_tdata_o[IdxLo+IdxW-1:IdxLo] != oldest.idx) begin
          report_mismatch("pixel_index", m_axis_tdata_o[IdxLo+IdxW-1:IdxLo], oldest.idx);
        end
        if (m_axis_tlast_o != oldest.done) begin
          report_mismatch("frame_done", m_axis_tlast_o, oldest.done);
        end
        if (m_axis_tuser_o != oldest.last) begin
          report_mismatch("last_of_item", m_axis_tuser_o, oldest.last);
        end
      end
    end
  end

  initial begin : timeout_guard
    #(TimeoutNs);
    $display("screen_dump_pixel_decoder test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_end;
    int unsigned pick;
    int unsigned count_byte;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= KindData;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CfgDecodeMode;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    model_mode  = mode_e'(CfgResetMode);
    model_frame = CfgResetFrame;
    model_phase = '0;
    model_hi    = '0;
    model_lo    = '0;
    model_count = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < NumSteps; i++) begin
      if (DirSteps[i].op == RowCfg) begin
        wait_idle();
        write_reg(DirSteps[i].sel, DirSteps[i].value);
      end else begin
        push_beat(DirSteps[i].kind, DirSteps[i].data, DirSteps[i].typed,
                  DirSteps[i].want);
      end
    end

    // Random phases. Each starts idle with a new mode and, usually, a new
    // frame size; its beats are mostly well-formed hex pairs or color
    // triples for that mode, with restarts and stray bytes that break the
    // grouping now and then.
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      write_reg(CfgDecodeMode, FrameW'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) != 0) write_reg(CfgFramePixels, pick_frame());
      phase_end = sent + $urandom_range(30, 80);
      while (sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          push_beat(KindRestart, 8'($urandom));
          sent += 1;
        end else if (pick <= 2) begin
          push_beat(KindData, 8'($urandom));
          sent += 1;
        end else if (model_mode == ModeMono) begin
          push_beat(KindData, lower_hex_char());
          push_beat(KindData, lower_hex_char());
          sent += 2;
        end else begin
          // Short counts dominate so small frames end often.
          if ($urandom_range(0, 9) == 0) count_byte = 0;
          else if ($urandom_range(0, 3) == 0) count_byte = $urandom_range(1, 255);
          else count_byte = $urandom_range(1, 16);
          push_beat(KindData, 8'($urandom));
          push_beat(KindData, 8'($urandom));
          push_beat(KindData, 8'(count_byte));
          sent += 3;
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("screen_dump_pixel_decoder test passed");
    end else begin
      $display("screen_dump_pixel_decoder test failed");
    end
    $finish;
  end

endmodule
